// ===== sv/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg: shared types and constants for the breakpoint address table
// Sizes, command codes, per-cell control structs and controller states.
// ----------------------------------------------------------------------------
package bat_pkg;

  localparam int ENTRIES    = 32;  // number of breakpoint slots, 1..32
  localparam int ADDR_WIDTH = 32;  // stored and compared address bits, 8..64

  localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CMD_W      = 2;
  localparam int IN_ADDR_W  = 32;
  localparam int OUT_SLOT_W = 5;

  typedef logic [ADDR_WIDTH-1:0] addr_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [CMD_W-1:0]      cmd_code_t;
  typedef logic [OUT_SLOT_W-1:0] out_slot_t;

  localparam cmd_code_t CMD_INSERT = 2'd0;
  localparam cmd_code_t CMD_REMOVE = 2'd1;
  localparam cmd_code_t CMD_FIND   = 2'd2;

  // per-slot update strobes for one match cell
  typedef struct packed {
    logic write;  // store key, set active
    logic clear;  // drop active
  } cell_ctl_t;

  // shift strobes for the free stack chain
  typedef struct packed {
    logic push;   // shift toward the bottom, new entry on top
    logic pop;    // shift toward the top
  } stack_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } bat_state_t;

endpackage

// ===== sv/bat_cmd_if.sv =====
// ----------------------------------------------------------------------------
// bat_cmd_if: command channel of the breakpoint address table
// Valid/ready handshake carrying the command code and the address.
// ----------------------------------------------------------------------------
interface bat_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [bat_pkg::CMD_W-1:0]       command;
  logic [bat_pkg::IN_ADDR_W-1:0]   address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

// ===== sv/bat_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bat_rsp_if: result channel of the breakpoint address table
// Valid/ready handshake carrying success, hit and slot number.
// ----------------------------------------------------------------------------
interface bat_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             success;
  logic                             hit;
  logic [bat_pkg::OUT_SLOT_W-1:0]   slot;

  modport source (output valid, output success, output hit, output slot, input ready);
  modport sink   (input valid, input success, input hit, input slot, output ready);
endinterface

// ===== sv/bat_match_cell.sv =====
// ----------------------------------------------------------------------------
// bat_match_cell: one breakpoint slot
// Holds address and active bit, registers the compare against the key.
// ----------------------------------------------------------------------------
module bat_match_cell (
  input  logic               clk,
  input  logic               rst,
  input  bat_pkg::cell_ctl_t ctl,
  input  bat_pkg::addr_t     key,
  output logic               active,
  output logic               match
);

  bat_pkg::addr_t addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.write) begin
      active <= 1'b1;
    end else if (ctl.clear) begin
      active <= 1'b0;
    end
  end

  // address has no reset: only compared while active
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      addr <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= active && (addr == key);
    end
  end

endmodule

// ===== sv/bat_stack_cell.sv =====
// ----------------------------------------------------------------------------
// bat_stack_cell: one entry of the free-slot stack chain
// Takes its upper neighbor on push, its lower neighbor on pop.
// ----------------------------------------------------------------------------
module bat_stack_cell (
  input  logic               clk,
  input  logic               rst,
  input  bat_pkg::stack_op_t op,
  input  bat_pkg::slot_t     init_slot,
  input  bat_pkg::slot_t     above,
  input  bat_pkg::slot_t     below,
  output bat_pkg::slot_t     slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= init_slot;
    end else if (op.push) begin
      slot <= above;
    end else if (op.pop) begin
      slot <= below;
    end
  end

endmodule

// ===== sv/breakpoint_address_table.sv =====
// ----------------------------------------------------------------------------
// breakpoint_address_table: breakpoint slot table with LIFO free list
// Sequence: command capture, registered compare (LOOK), update and result register (EXEC).
// A new command is taken only as the previous one finishes, set by the registered
//   compare in the match cells followed by the update state; a stalled result holds the update.
// Reset: all slots inactive, free stack holds slots 0..ENTRIES-1 with 0 on top,
//   free count ENTRIES; stored addresses are left as they are.
// ----------------------------------------------------------------------------
module breakpoint_address_table (
  input  logic       clk,
  input  logic       rst,
  bat_cmd_if.sink    cmd,
  bat_rsp_if.source  rsp
);

  localparam int N = bat_pkg::ENTRIES;

  // controller
  bat_pkg::bat_state_t state;
  bat_pkg::bat_state_t state_next;

  // captured command
  bat_pkg::cmd_code_t  command;
  bat_pkg::addr_t      key;

  // match cells
  bat_pkg::cell_ctl_t  ctl [N];
  logic [N-1:0]        active;
  logic [N-1:0]        match;

  // free stack chain, cell 0 is the top
  bat_pkg::slot_t      stk [N];
  bat_pkg::stack_op_t  sop;
  bat_pkg::count_t     free_count;

  // decode of the update cycle
  logic                take;
  logic                finish;
  logic                hit;
  bat_pkg::slot_t      hit_slot;
  logic                is_insert;
  logic                is_remove;
  logic                is_find;
  logic                do_pop;
  logic                do_clear;
  logic                success_next;
  logic                hit_next;
  bat_pkg::slot_t      slot_next;

  // --------------------------------------------------------------------------
  // Handshake. A new command may enter in the cycle the previous one
  // finishes, so its compare sees the updated table.
  // --------------------------------------------------------------------------
  assign finish    = (state == bat_pkg::ST_EXEC) && (!rsp.valid || rsp.ready);
  assign cmd.ready = (state == bat_pkg::ST_IDLE) || finish;
  assign take      = cmd.valid && cmd.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      bat_pkg::ST_IDLE: begin
        if (take) state_next = bat_pkg::ST_LOOK;
      end
      bat_pkg::ST_LOOK: begin
        state_next = bat_pkg::ST_EXEC;
      end
      bat_pkg::ST_EXEC: begin
        if (finish) state_next = take ? bat_pkg::ST_LOOK : bat_pkg::ST_IDLE;
      end
      default: begin
        state_next = bat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture; address keeps the low ADDR_WIDTH bits
  always_ff @(posedge clk) begin
    if (take) begin
      command <= cmd.command;
      key     <= bat_pkg::addr_t'(cmd.address);
    end
  end

  // --------------------------------------------------------------------------
  // Match cells: one per slot, compare registered during the LOOK cycle.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_slot
    bat_match_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl[i]),
      .key    (key),
      .active (active[i]),
      .match  (match[i])
    );
  end

  // At most one cell matches, so the slot number is an OR of indices.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) hit_slot = hit_slot | bat_pkg::slot_t'(i);
    end
  end
  assign hit = |match;

  // --------------------------------------------------------------------------
  // Update decode (EXEC cycle).
  // Insert miss with a free slot pops the top of the stack into the table.
  // Remove hit clears the slot and pushes it back on top.
  // The unused command code reports no hit even when the address is active.
  // --------------------------------------------------------------------------
  always_comb begin
    is_insert    = (command == bat_pkg::CMD_INSERT);
    is_remove    = (command == bat_pkg::CMD_REMOVE);
    is_find      = (command == bat_pkg::CMD_FIND);
    hit_next     = hit && (is_insert || is_remove || is_find);
    do_pop       = finish && is_insert && !hit && (free_count != '0);
    do_clear     = finish && is_remove && hit;
    sop.pop      = do_pop;
    sop.push     = do_clear && (free_count != bat_pkg::count_t'(N));
    success_next = 1'b0;
    slot_next    = '0;
    if (hit_next) begin
      success_next = 1'b1;
      slot_next    = hit_slot;
    end else if (is_insert && (free_count != '0)) begin
      success_next = 1'b1;
      slot_next    = stk[0];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_ctl
    assign ctl[i].write = do_pop && (stk[0] == bat_pkg::slot_t'(i));
    assign ctl[i].clear = do_clear && (hit_slot == bat_pkg::slot_t'(i));
  end

  // --------------------------------------------------------------------------
  // Free stack chain: every cell shifts together on push or pop.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_stack
    bat_pkg::slot_t above;
    bat_pkg::slot_t below;
    if (i == 0) begin : g_top
      assign above = hit_slot;
    end else begin : g_mid
      assign above = stk[i-1];
    end
    if (i == N - 1) begin : g_bot
      assign below = stk[i];
    end else begin : g_upper
      assign below = stk[i+1];
    end
    bat_stack_cell u_stk (
      .clk       (clk),
      .rst       (rst),
      .op        (sop),
      .init_slot (bat_pkg::slot_t'(i)),
      .above     (above),
      .below     (below),
      .slot      (stk[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= bat_pkg::count_t'(N);
    end else if (sop.pop) begin
      free_count <= free_count - 1'b1;
    end else if (sop.push) begin
      free_count <= free_count + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: parts the table from the consumer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.success <= success_next;
      rsp.hit     <= hit_next;
      rsp.slot    <= bat_pkg::out_slot_t'(slot_next);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one slot matches the key");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= bat_pkg::count_t'(N))
    else $error("free count above table size");

  a_count_tracks_active: assert property (@(posedge clk) disable iff (rst)
    ($countones(active) + int'(free_count)) == N)
    else $error("free count disagrees with active slots");

  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == bat_pkg::ST_EXEC))
    else $error("result raised outside the update cycle");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(sop.push && sop.pop))
    else $error("free stack pushed and popped together");

endmodule
